// ===== src/bwr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bwr_pkg;

    localparam int unsigned POS_W   = 32;
    localparam int unsigned LEN_W   = 31;
    localparam int unsigned TRANS_W = 33;
    localparam int unsigned TSUM_W  = 35;
    localparam int unsigned HIT_W   = 32;
    localparam int unsigned MOMT_W  = 63;
    localparam int unsigned ADDR_W  = 4;
    localparam int unsigned DATA_W  = 32;

    localparam logic [LEN_W-1:0] BOX_LEN_RESET = 31'd65536;

    localparam logic [1:0] REG_BOX_LEN_X = 2'd0;
    localparam logic [1:0] REG_BOX_LEN_Y = 2'd1;
    localparam logic [1:0] REG_BOX_LEN_Z = 2'd2;

    localparam logic OP_CONTAIN = 1'b0;
    localparam logic OP_CLEAR   = 1'b1;

    typedef struct packed {
        logic                      hit;
        logic                      bad;
        logic signed [POS_W-1:0]   pos;
        logic signed [POS_W-1:0]   mom;
        logic        [TRANS_W-1:0] trans;
    } t_axis_res;

endpackage

`default_nettype wire

// ===== src/box_wall_reflection_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Reflecting box walls for one particle in Q16.16. Two register stages: a
// request lands in the input register, where its three axes are checked,
// mirrored and folded into the hit and momentum totals as it moves on into
// the result register. One request per cycle is sustained while the output
// is not stalled; the limit is the single path from input register through
// the per-axis mirror and the 63-bit total update into the result and total
// registers. The totals shown with a result are the running totals after
// that request. Box lengths sit at APB offsets 0x0, 0x4, 0x8 and must only
// be written while the block is idle.
module box_wall_reflection_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,

    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [bwr_pkg::ADDR_W-1:0]          paddr,
    input  logic [bwr_pkg::DATA_W-1:0]          pwdata,
    output logic [bwr_pkg::DATA_W-1:0]          prdata,
    output logic                                pready,

    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_opcode,
    input  logic signed [bwr_pkg::POS_W-1:0]    i_old_pos_x,
    input  logic signed [bwr_pkg::POS_W-1:0]    i_old_pos_y,
    input  logic signed [bwr_pkg::POS_W-1:0]    i_old_pos_z,
    input  logic signed [bwr_pkg::POS_W-1:0]    i_new_pos_x,
    input  logic signed [bwr_pkg::POS_W-1:0]    i_new_pos_y,
    input  logic signed [bwr_pkg::POS_W-1:0]    i_new_pos_z,
    input  logic signed [bwr_pkg::POS_W-1:0]    i_mom_x,
    input  logic signed [bwr_pkg::POS_W-1:0]    i_mom_y,
    input  logic signed [bwr_pkg::POS_W-1:0]    i_mom_z,

    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [bwr_pkg::POS_W-1:0]    o_out_pos_x,
    output logic signed [bwr_pkg::POS_W-1:0]    o_out_pos_y,
    output logic signed [bwr_pkg::POS_W-1:0]    o_out_pos_z,
    output logic signed [bwr_pkg::POS_W-1:0]    o_out_mom_x,
    output logic signed [bwr_pkg::POS_W-1:0]    o_out_mom_y,
    output logic signed [bwr_pkg::POS_W-1:0]    o_out_mom_z,
    output logic [1:0]                          o_reflect_count,
    output logic                                o_step_too_large,
    output logic [bwr_pkg::HIT_W-1:0]           o_total_hits,
    output logic [bwr_pkg::MOMT_W-1:0]          o_total_momentum
);
    import bwr_pkg::*;

    // configuration
    logic [LEN_W-1:0] r_box_len [3];
    logic             cfg_wr;
    logic [1:0]       cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box_len[0] <= BOX_LEN_RESET;
            r_box_len[1] <= BOX_LEN_RESET;
            r_box_len[2] <= BOX_LEN_RESET;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_BOX_LEN_X: r_box_len[0] <= pwdata[LEN_W-1:0];
                REG_BOX_LEN_Y: r_box_len[1] <= pwdata[LEN_W-1:0];
                REG_BOX_LEN_Z: r_box_len[2] <= pwdata[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_BOX_LEN_X: prdata = {1'b0, r_box_len[0]};
            REG_BOX_LEN_Y: prdata = {1'b0, r_box_len[1]};
            REG_BOX_LEN_Z: prdata = {1'b0, r_box_len[2]};
            default:       prdata = '0;
        endcase
    end

    // input register
    logic                    r_s1_valid;
    logic                    r_s1_op;
    logic signed [POS_W-1:0] r_s1_old [3];
    logic signed [POS_W-1:0] r_s1_new [3];
    logic signed [POS_W-1:0] r_s1_mom [3];
    logic                    advance;
    logic                    in_acc;

    assign advance    = r_s1_valid && (!o_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || advance;
    assign in_acc     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_op     <= i_opcode;
            r_s1_old[0] <= i_old_pos_x;
            r_s1_old[1] <= i_old_pos_y;
            r_s1_old[2] <= i_old_pos_z;
            r_s1_new[0] <= i_new_pos_x;
            r_s1_new[1] <= i_new_pos_y;
            r_s1_new[2] <= i_new_pos_z;
            r_s1_mom[0] <= i_mom_x;
            r_s1_mom[1] <= i_mom_y;
            r_s1_mom[2] <= i_mom_z;
        end
    end

    // per-axis reflection
    t_axis_res axis_res [3];
    logic      clear_op;

    assign clear_op = (r_s1_op == OP_CLEAR);

    for (genvar a = 0; a < 3; a++) begin : g_axis
        bwr_axis u_axis (
            .i_clear   (clear_op),
            .i_len     (r_box_len[a]),
            .i_old_pos (r_s1_old[a]),
            .i_new_pos (r_s1_new[a]),
            .i_mom     (r_s1_mom[a]),
            .o_res     (axis_res[a])
        );
    end

    logic              bad_any;
    logic [1:0]        hit_cnt;
    logic [TSUM_W-1:0] trans_sum;

    always_comb begin
        bad_any   = axis_res[0].bad || axis_res[1].bad || axis_res[2].bad;
        hit_cnt   = bad_any ? 2'd0
                  : ({1'b0, axis_res[0].hit} + {1'b0, axis_res[1].hit}
                     + {1'b0, axis_res[2].hit});
        trans_sum = {2'b00, axis_res[0].trans} + {2'b00, axis_res[1].trans}
                  + {2'b00, axis_res[2].trans};
    end

    bwr_totals u_totals (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_clear     (advance && clear_op),
        .i_add       (advance && !clear_op && !bad_any),
        .i_hits      (hit_cnt),
        .i_trans     (trans_sum),
        .o_hit_total (o_total_hits),
        .o_mom_total (o_total_momentum)
    );

    // result register; totals change only when a result loads, so they are
    // read straight from the accumulator
    logic                    r_out_valid;
    logic signed [POS_W-1:0] r_out_pos [3];
    logic signed [POS_W-1:0] r_out_mom [3];
    logic [1:0]              r_out_refl;
    logic                    r_out_bad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            for (int a = 0; a < 3; a++) begin
                r_out_pos[a] <= bad_any ? r_s1_new[a] : axis_res[a].pos;
                r_out_mom[a] <= bad_any ? r_s1_mom[a] : axis_res[a].mom;
            end
            r_out_refl <= hit_cnt;
            r_out_bad  <= bad_any;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_out_pos_x      = r_out_pos[0];
    assign o_out_pos_y      = r_out_pos[1];
    assign o_out_pos_z      = r_out_pos[2];
    assign o_out_mom_x      = r_out_mom[0];
    assign o_out_mom_y      = r_out_mom[1];
    assign o_out_mom_z      = r_out_mom[2];
    assign o_reflect_count  = r_out_refl;
    assign o_step_too_large = r_out_bad;

endmodule

`default_nettype wire

// ===== src/bwr_axis.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bwr_axis (
    input  logic                              i_clear,
    input  logic        [bwr_pkg::LEN_W-1:0]  i_len,
    input  logic signed [bwr_pkg::POS_W-1:0]  i_old_pos,
    input  logic signed [bwr_pkg::POS_W-1:0]  i_new_pos,
    input  logic signed [bwr_pkg::POS_W-1:0]  i_mom,
    output bwr_pkg::t_axis_res                o_res
);
    import bwr_pkg::*;

    logic              outside;
    logic [POS_W:0]    diff;
    logic              fwd;
    logic [POS_W+1:0]  r_ext;
    logic [POS_W+1:0]  rf;
    logic              rf_bad;
    logic [POS_W-1:0]  mag;
    logic [POS_W-1:0]  mom_neg;

    always_comb begin
        outside = i_new_pos[POS_W-1] || (i_new_pos[POS_W-2:0] > i_len);
        diff    = {i_new_pos[POS_W-1], i_new_pos} - {i_old_pos[POS_W-1], i_old_pos};
        fwd     = !diff[POS_W] && (diff != '0);
        r_ext   = {{2{i_new_pos[POS_W-1]}}, i_new_pos};
        if (fwd) begin
            rf = {2'b00, i_len, 1'b0} - r_ext;
        end else begin
            rf = '0 - r_ext;
        end
        rf_bad  = rf[POS_W+1] || (rf[POS_W:0] > {2'b00, i_len});

        mag     = i_mom[POS_W-1] ? (~i_mom + 1'b1) : i_mom;
        mom_neg = (i_mom == {1'b1, {(POS_W-1){1'b0}}}) ? {1'b0, {(POS_W-1){1'b1}}}
                                                       : (~i_mom + 1'b1);

        o_res.hit   = !i_clear && outside;
        o_res.bad   = o_res.hit && rf_bad;
        o_res.pos   = o_res.hit ? rf[POS_W-1:0] : i_new_pos;
        o_res.mom   = o_res.hit ? mom_neg : i_mom;
        o_res.trans = o_res.hit ? {mag, 1'b0} : '0;
    end

endmodule

`default_nettype wire

// ===== src/bwr_totals.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bwr_totals (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_clear,
    input  logic                          i_add,
    input  logic [1:0]                    i_hits,
    input  logic [bwr_pkg::TSUM_W-1:0]    i_trans,
    output logic [bwr_pkg::HIT_W-1:0]     o_hit_total,
    output logic [bwr_pkg::MOMT_W-1:0]    o_mom_total
);
    import bwr_pkg::*;

    logic [HIT_W-1:0]  r_hit;
    logic [MOMT_W-1:0] r_mom;
    logic [HIT_W-1:0]  n_hit;
    logic [MOMT_W-1:0] n_mom;
    logic [HIT_W:0]    hit_sum;
    logic [MOMT_W:0]   mom_sum;

    always_comb begin
        hit_sum = {1'b0, r_hit} + {{(HIT_W-1){1'b0}}, i_hits};
        mom_sum = {1'b0, r_mom} + {{(MOMT_W+1-TSUM_W){1'b0}}, i_trans};
        n_hit   = r_hit;
        n_mom   = r_mom;
        if (i_clear) begin
            n_hit = '0;
            n_mom = '0;
        end else if (i_add) begin
            n_hit = hit_sum[HIT_W] ? '1 : hit_sum[HIT_W-1:0];
            n_mom = mom_sum[MOMT_W] ? '1 : mom_sum[MOMT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= '0;
            r_mom <= '0;
        end else begin
            r_hit <= n_hit;
            r_mom <= n_mom;
        end
    end

    assign o_hit_total = r_hit;
    assign o_mom_total = r_mom;

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import bwr_pkg::*;

    localparam int LIMIT = 400000;
    localparam int PHASES = 6;
    localparam int ITEMS_PER_PHASE = 84;
    localparam logic [1:0] BOX_REGS[3] = '{REG_BOX_LEN_X, REG_BOX_LEN_Y, REG_BOX_LEN_Z};
    localparam longint MOM_LIMIT = 64'sd2147483647;
    localparam logic [MOMT_W-1:0] MOMT_MAX = '1;

    typedef struct {
        logic op;
        int   old_p[3];
        int   new_p[3];
        int   mom[3];
    } particle_req_t;

    typedef struct {
        logic signed [POS_W-1:0]  pos[3];
        logic signed [POS_W-1:0]  mom[3];
        logic [1:0]               refl;
        logic                     too_large;
        logic [HIT_W-1:0]         hits;
        logic [MOMT_W-1:0]        momt;
    } bounce_res_t;

    class wall_bounce_sb;
        longint            box_len[3];
        logic [HIT_W-1:0]  hit_total;
        logic [MOMT_W-1:0] mom_total;
        bounce_res_t       expected_bounces[$];
        int unsigned       mismatches;

        function new();
            box_len = '{65536, 65536, 65536};
            hit_total = '0;
            mom_total = '0;
            mismatches = 0;
        endfunction

        function int pending();
            return expected_bounces.size();
        endfunction

        function void note_request(particle_req_t rq);
            longint oldp, newp, p, len, mirrored;
            logic [63:0] trans;
            logic [32:0] hit_sum;
            logic bad;
            int refl;
            bounce_res_t e;
            trans = '0;
            bad = 1'b0;
            refl = 0;
            for (int a = 0; a < 3; a++) begin
                oldp = rq.old_p[a];
                newp = rq.new_p[a];
                p = rq.mom[a];
                len = box_len[a];
                e.pos[a] = rq.new_p[a];
                e.mom[a] = rq.mom[a];
                if (rq.op == OP_CLEAR || (newp >= 0 && newp <= len))
                    continue;
                e.mom[a] = POS_W'((-p > MOM_LIMIT) ? MOM_LIMIT : -p);
                refl++;
                trans += (p < 0 ? -p : p) << 1;
                mirrored = (newp - oldp > 0) ? 2 * len - newp : -newp;
                if (mirrored < 0 || mirrored > len)
                    bad = 1'b1;
                e.pos[a] = POS_W'(mirrored);
            end
            if (rq.op == OP_CLEAR) begin
                hit_total = '0;
                mom_total = '0;
            end
            if (bad) begin
                for (int a = 0; a < 3; a++) begin
                    e.pos[a] = rq.new_p[a];
                    e.mom[a] = rq.mom[a];
                end
                refl = 0;
            end else if (refl > 0) begin
                hit_sum = {1'b0, hit_total} + 33'(refl);
                hit_total = hit_sum[32] ? '1 : hit_sum[31:0];
                if (trans > MOMT_MAX - mom_total)
                    mom_total = MOMT_MAX;
                else
                    mom_total = mom_total + trans[MOMT_W-1:0];
            end
            e.refl = 2'(refl);
            e.too_large = bad;
            e.hits = hit_total;
            e.momt = mom_total;
            expected_bounces.push_back(e);
        endfunction

        function void compare_field(string fname, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                $error("%s: expected %0h, got %0h", fname, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(bounce_res_t got);
            bounce_res_t want;
            string ax[3] = '{"x", "y", "z"};
            if (expected_bounces.size() == 0) begin
                $error("result with no request pending");
                mismatches++;
                return;
            end
            want = expected_bounces.pop_front();
            for (int a = 0; a < 3; a++) begin
                compare_field({"out_pos_", ax[a]}, want.pos[a], got.pos[a]);
                compare_field({"out_mom_", ax[a]}, want.mom[a], got.mom[a]);
            end
            compare_field("reflect_count", want.refl, got.refl);
            compare_field("step_too_large", want.too_large, got.too_large);
            compare_field("total_hits", want.hits, got.hits);
            compare_field("total_momentum", want.momt, got.momt);
        endfunction
    endclass

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      psel;
    logic                      penable;
    logic                      pwrite;
    logic [ADDR_W-1:0]         paddr;
    logic [DATA_W-1:0]         pwdata;
    logic [DATA_W-1:0]         prdata;
    logic                      pready;
    logic                      i_in_valid;
    logic                      o_in_ready;
    logic                      i_opcode;
    logic signed [POS_W-1:0]   i_old_pos_x, i_old_pos_y, i_old_pos_z;
    logic signed [POS_W-1:0]   i_new_pos_x, i_new_pos_y, i_new_pos_z;
    logic signed [POS_W-1:0]   i_mom_x, i_mom_y, i_mom_z;
    logic                      o_out_valid;
    logic                      i_out_ready;
    logic signed [POS_W-1:0]   o_out_pos_x, o_out_pos_y, o_out_pos_z;
    logic signed [POS_W-1:0]   o_out_mom_x, o_out_mom_y, o_out_mom_z;
    logic [1:0]                o_reflect_count;
    logic                      o_step_too_large;
    logic [HIT_W-1:0]          o_total_hits;
    logic [MOMT_W-1:0]         o_total_momentum;

    wall_bounce_sb sb;
    particle_req_t cur_req;
    bounce_res_t   seen_res;
    int            calm;
    int            cycle_count;

    box_wall_reflection_top dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_opcode         (i_opcode),
        .i_old_pos_x      (i_old_pos_x),
        .i_old_pos_y      (i_old_pos_y),
        .i_old_pos_z      (i_old_pos_z),
        .i_new_pos_x      (i_new_pos_x),
        .i_new_pos_y      (i_new_pos_y),
        .i_new_pos_z      (i_new_pos_z),
        .i_mom_x          (i_mom_x),
        .i_mom_y          (i_mom_y),
        .i_mom_z          (i_mom_z),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_out_pos_x      (o_out_pos_x),
        .o_out_pos_y      (o_out_pos_y),
        .o_out_pos_z      (o_out_pos_z),
        .o_out_mom_x      (o_out_mom_x),
        .o_out_mom_y      (o_out_mom_y),
        .o_out_mom_z      (o_out_mom_z),
        .o_reflect_count  (o_reflect_count),
        .o_step_too_large (o_step_too_large),
        .o_total_hits     (o_total_hits),
        .o_total_momentum (o_total_momentum)
    );

    initial i_clk = 0;
    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                seen_res.pos[0] = o_out_pos_x;
                seen_res.pos[1] = o_out_pos_y;
                seen_res.pos[2] = o_out_pos_z;
                seen_res.mom[0] = o_out_mom_x;
                seen_res.mom[1] = o_out_mom_y;
                seen_res.mom[2] = o_out_mom_z;
                seen_res.refl = o_reflect_count;
                seen_res.too_large = o_step_too_large;
                seen_res.hits = o_total_hits;
                seen_res.momt = o_total_momentum;
                sb.check_result(seen_res);
            end
            if (i_in_valid && o_in_ready)
                sb.note_request(cur_req);
        end
    end

    initial begin
        int stall;
        stall = 0;
        i_out_ready = 0;
        forever begin
            @(negedge i_clk);
            if (stall > 0) begin
                i_out_ready <= 0;
                stall--;
            end else if (calm > 0 || $urandom_range(0, 99) < 60) begin
                i_out_ready <= 1;
            end else begin
                i_out_ready <= 0;
                stall = ($urandom_range(0, 99) < 90) ? $urandom_range(0, 3)
                                                     : $urandom_range(15, 60);
            end
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tb: errors");
        $finish;
    end

    task automatic send_particle(particle_req_t rq);
        int gap;
        int r;
        r = $urandom_range(0, 99);
        if (calm > 0) begin
            gap = 0;
            calm--;
        end else if (r < 55) gap = 0;
        else if (r < 88) gap = $urandom_range(1, 3);
        else if (r < 97) gap = $urandom_range(4, 12);
        else gap = $urandom_range(20, 60);
        if (gap > 0) begin
            @(negedge i_clk) i_in_valid <= 0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        cur_req = rq;
        i_in_valid  <= 1;
        i_opcode    <= rq.op;
        i_old_pos_x <= rq.old_p[0];
        i_old_pos_y <= rq.old_p[1];
        i_old_pos_z <= rq.old_p[2];
        i_new_pos_x <= rq.new_p[0];
        i_new_pos_y <= rq.new_p[1];
        i_new_pos_z <= rq.new_p[2];
        i_mom_x     <= rq.mom[0];
        i_mom_y     <= rq.mom[1];
        i_mom_z     <= rq.mom[2];
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
    endtask

    // drop the request line and let the pipeline empty out
    task automatic wait_idle();
        @(negedge i_clk) i_in_valid <= 0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_box_len(logic [1:0] idx, logic [LEN_W-1:0] val);
        @(negedge i_clk);
        psel    <= 1;
        penable <= 0;
        pwrite  <= 1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {1'b0, val};
        @(negedge i_clk) penable <= 1;
        do @(posedge i_clk); while (pready !== 1'b1);
        sb.box_len[idx] = val;
        @(negedge i_clk);
        psel    <= 0;
        penable <= 0;
        pwrite  <= 0;
        @(negedge i_clk);
        psel    <= 1;
        penable <= 0;
        paddr   <= {idx, 2'b00};
        @(negedge i_clk) penable <= 1;
        do @(posedge i_clk); while (pready !== 1'b1);
        if (prdata !== {1'b0, val}) begin
            $error("box_len readback: expected %0h, got %0h", {1'b0, val}, prdata);
            sb.mismatches++;
        end
        @(negedge i_clk);
        psel    <= 0;
        penable <= 0;
    endtask

    function automatic particle_req_t mk(logic op, int ox, int oy, int oz, int nx, int ny,
                                         int nz, int px, int py, int pz);
        particle_req_t rq;
        rq.op = op;
        rq.old_p = '{ox, oy, oz};
        rq.new_p = '{nx, ny, nz};
        rq.mom = '{px, py, pz};
        return rq;
    endfunction

    // mostly in-box moves and single wall crossings; some overshoot and raw noise
    function automatic void random_axis(longint len, output int o, output int n);
        longint lo, nw, span;
        int unsigned mode;
        mode = $urandom_range(0, 99);
        span = (len > 0) ? len : 1;
        if (mode < 45) begin
            nw = $urandom_range(0, len);
            lo = $urandom_range(0, len);
        end else if (mode < 65) begin
            nw = len + $urandom_range(1, span);
            lo = nw - 1 - $urandom_range(0, 16'hffff);
        end else if (mode < 85) begin
            nw = -longint'($urandom_range(1, span));
            lo = nw + 1 + $urandom_range(0, 16'hffff);
        end else if (mode < 93) begin
            if ($urandom_range(0, 1)) begin
                nw = 2 * len + 1 + $urandom_range(0, 16'hffff);
                lo = nw - 1;
            end else begin
                nw = -len - 1 - $urandom_range(0, 16'hffff);
                lo = nw + 1;
            end
        end else begin
            nw = int'($urandom);
            lo = int'($urandom);
        end
        o = int'(lo);
        n = int'(nw);
    endfunction

    function automatic particle_req_t random_particle();
        particle_req_t rq;
        int o, n;
        rq.op = ($urandom_range(0, 99) < 6) ? OP_CLEAR : OP_CONTAIN;
        for (int a = 0; a < 3; a++) begin
            random_axis(sb.box_len[a], o, n);
            rq.old_p[a] = o;
            rq.new_p[a] = n;
            case ($urandom_range(0, 11))
                0:       rq.mom[a] = 32'h8000_0000;
                1:       rq.mom[a] = 32'h7fff_ffff;
                2:       rq.mom[a] = 0;
                default: rq.mom[a] = $urandom;
            endcase
        end
        return rq;
    endfunction

    initial begin
        logic [LEN_W-1:0] fixed_len[3][3];
        logic [LEN_W-1:0] len_val;
        fixed_len = '{'{31'd0, 31'h7fff_ffff, 31'd196608},
                      '{31'd1, 31'd16, 31'h7fff_ffff},
                      '{31'h7fff_ffff, 31'd0, 31'd1}};
        sb = new();
        calm = 0;
        i_rst_n = 0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = '0;
        pwdata = '0;
        i_in_valid = 0;
        i_opcode = OP_CONTAIN;
        {i_old_pos_x, i_old_pos_y, i_old_pos_z} = '0;
        {i_new_pos_x, i_new_pos_y, i_new_pos_z} = '0;
        {i_mom_x, i_mom_y, i_mom_z} = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1;

        // box is 1.0 on every axis after reset
        send_particle(mk(OP_CONTAIN, 'h8000, 'h8000, 'h8000, 'h9000, 'h9000, 'h9000,
                         'h100, 'h100, 'h100));
        send_particle(mk(OP_CONTAIN, 'h10, 'hff00, 'h8000, 0, 'h10000, 'h8000, 0, 0, 0));
        send_particle(mk(OP_CONTAIN, 'hf000, 'h8000, 'h8000, 'h11000, 'h8000, 'h8000,
                         'h2345, 'h10, 'h20));
        send_particle(mk(OP_CONTAIN, 'h8000, 'h1000, 'h8000, 'h8000, -32'sh800, 'h8000,
                         'h10, -32'sh300, 'h20));
        send_particle(mk(OP_CONTAIN, 'h10, 'hfff0, -1, -32'sh10, 'h10010, -1,
                         'h1234, -32'sh5678, 'h9abc));
        send_particle(mk(OP_CONTAIN, 'hf000, 'h1000, 'h8000, 'h10800, -32'sh100, 'h8000,
                         32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000));
        send_particle(mk(OP_CONTAIN, 0, 'hf000, 'h8000, 'h30000, 'h10100, 'h8000,
                         'h111, 'h222, 'h333));
        send_particle(mk(OP_CONTAIN, 'h10001, 'h8000, 'h8000, 'h10001, 'h8000, 'h8000,
                         'h40, 'h40, 'h40));
        send_particle(mk(OP_CONTAIN, 32'h8000_0000, 'h8000, 'h8000, 32'h7fff_ffff, 'h8000,
                         'h8000, 32'h8000_0000, 32'h7fff_ffff, 0));
        send_particle(mk(OP_CONTAIN, 'h8000, 32'h7fff_ffff, 'h8000, 'h8000, 32'h8000_0000,
                         'h8000, 0, 32'h8000_0000, 32'h7fff_ffff));
        send_particle(mk(OP_CLEAR, 0, 0, 0, 'h30000, -32'sh30000, 'h10001,
                         'h55, -32'sh66, 'h77));
        send_particle(mk(OP_CONTAIN, 'hf000, 'h8000, 'h8000, 'h10010, 'h8000, 'h8000,
                         -32'sh1000, 'h10, 'h10));
        send_particle(mk(OP_CLEAR, -1, -1, -1, -1, -1, -1, -1, -1, -1));
        send_particle(mk(OP_CONTAIN, -1, -1, -1, -1, -1, -1, -1, -1, -1));
        send_particle(mk(OP_CONTAIN, 0, 0, 0, 0, 0, 0, 0, 0, 0));

        for (int ph = 0; ph < PHASES; ph++) begin
            wait_idle();
            for (int r = 0; r < 3; r++) begin
                if (ph < 3)
                    len_val = fixed_len[ph][r];
                else if ($urandom_range(0, 3) == 0)
                    len_val = LEN_W'($urandom_range(0, 32'h7fff_ffff));
                else
                    len_val = LEN_W'($urandom_range(1, 1 << 24));
                set_box_len(BOX_REGS[r], len_val);
            end
            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                if (i % 60 == 0 && $urandom_range(0, 2) == 0)
                    calm = 30;
                if (i == 40)
                    wait_idle();
                send_particle(random_particle());
            end
        end

        wait_idle();
        repeat (8) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
